// File: sv/srmm_pkg.sv
`timescale 1ns / 1ps
package srmm_pkg;

  // fixed field widths of the ports
  localparam int DIM_W  = 5;
  localparam int IN_W   = 32;
  localparam int OUT_W  = 32;
  localparam int CNT_W  = 2 * DIM_W;
  localparam int STEP_W = 4;

  // register indexes on the configuration port
  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  // microcode steps
  localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_INIT    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_RD_A    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_LO_RD_B = 4'd3;
  localparam logic [STEP_W-1:0] STEP_HI_NEXT = 4'd4;
  localparam logic [STEP_W-1:0] STEP_TEST    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_PROBE   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_CMP     = 4'd7;
  localparam logic [STEP_W-1:0] STEP_ROW_END = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DECIDE  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_DONE    = 4'd10;

  // jump conditions
  localparam logic [2:0] COND_NONE      = 3'd0;
  localparam logic [2:0] COND_ALWAYS    = 3'd1;
  localparam logic [2:0] COND_START     = 3'd2;
  localparam logic [2:0] COND_MORE_ROWS = 3'd3;
  localparam logic [2:0] COND_EMPTY     = 3'd4;
  localparam logic [2:0] COND_N_ZERO    = 3'd5;
  localparam logic [2:0] COND_OUT_FREE  = 3'd6;

  // read address select
  localparam logic [1:0] ADDR_BASE  = 2'd0;
  localparam logic [1:0] ADDR_LAST  = 2'd1;
  localparam logic [1:0] ADDR_PROBE = 2'd2;

  // bound register ops (shared by low and high bound)
  localparam logic [1:0] BND_HOLD   = 2'd0;
  localparam logic [1:0] BND_LOAD   = 2'd1;
  localparam logic [1:0] BND_DECIDE = 2'd2;

  localparam logic [1:0] ROW_HOLD  = 2'd0;
  localparam logic [1:0] ROW_CLEAR = 2'd1;
  localparam logic [1:0] ROW_NEXT  = 2'd2;

  localparam logic [1:0] PRB_HOLD  = 2'd0;
  localparam logic [1:0] PRB_RESET = 2'd1;
  localparam logic [1:0] PRB_STEP  = 2'd2;

  localparam logic [1:0] CNT_HOLD  = 2'd0;
  localparam logic [1:0] CNT_CLEAR = 2'd1;
  localparam logic [1:0] CNT_ADD   = 2'd2;

  localparam logic [1:0] BEST_HOLD   = 2'd0;
  localparam logic [1:0] BEST_INIT   = 2'd1;
  localparam logic [1:0] BEST_DECIDE = 2'd2;

  typedef struct packed {
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
    logic              hold;
    logic              mem_rd;
    logic [1:0]        addr_sel;
    logic [1:0]        lo_op;
    logic [1:0]        hi_op;
    logic [1:0]        row_op;
    logic [1:0]        prb_op;
    logic [1:0]        cnt_op;
    logic              mid_ld;
    logic [1:0]        best_op;
    logic              rank_ld;
    logic              out_ld;
  } ctrl_t;

  typedef struct packed {
    logic more_rows;
    logic empty;
    logic n_zero;
  } flags_t;

  typedef struct packed {
    logic   start;
    logic   out_free;
    flags_t dp;
  } status_t;

  // control store
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '0;
    unique case (step)
      STEP_IDLE: begin
        w.cond   = COND_START;
        w.target = STEP_INIT;
        w.hold   = 1'b1;
      end
      STEP_INIT: begin
        w.row_op  = ROW_CLEAR;
        w.rank_ld = 1'b1;
        w.best_op = BEST_INIT;
      end
      STEP_RD_A: begin
        w.mem_rd   = 1'b1;
        w.addr_sel = ADDR_BASE;
      end
      STEP_LO_RD_B: begin
        w.lo_op    = BND_LOAD;
        w.mem_rd   = 1'b1;
        w.addr_sel = ADDR_LAST;
      end
      STEP_HI_NEXT: begin
        w.hi_op  = BND_LOAD;
        w.row_op = ROW_NEXT;
        w.cond   = COND_MORE_ROWS;
        w.target = STEP_RD_A;
      end
      STEP_TEST: begin
        w.cond   = COND_EMPTY;
        w.target = STEP_DONE;
        w.mid_ld = 1'b1;
        w.row_op = ROW_CLEAR;
        w.prb_op = PRB_RESET;
        w.cnt_op = CNT_CLEAR;
      end
      STEP_PROBE: begin
        w.cond     = COND_N_ZERO;
        w.target   = STEP_ROW_END;
        w.mem_rd   = 1'b1;
        w.addr_sel = ADDR_PROBE;
      end
      STEP_CMP: begin
        w.prb_op = PRB_STEP;
        w.cond   = COND_ALWAYS;
        w.target = STEP_PROBE;
      end
      STEP_ROW_END: begin
        w.cnt_op = CNT_ADD;
        w.row_op = ROW_NEXT;
        w.prb_op = PRB_RESET;
        w.cond   = COND_MORE_ROWS;
        w.target = STEP_PROBE;
      end
      STEP_DECIDE: begin
        w.lo_op   = BND_DECIDE;
        w.hi_op   = BND_DECIDE;
        w.best_op = BEST_DECIDE;
        w.cond    = COND_ALWAYS;
        w.target  = STEP_TEST;
      end
      STEP_DONE: begin
        w.out_ld = 1'b1;
        w.cond   = COND_OUT_FREE;
        w.target = STEP_IDLE;
        w.hold   = 1'b1;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: sv/sorted_rows_matrix_median_unit.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+-----------------------------------
// in_     | slave     | tvalid/tready      | tdata: element_value, tlast: last
// out_    | master    | tvalid/tready      | tdata: median_value
// cfg_    | write     | we                 | index 0 row_count, 1 col_count
//
// Elements load at one per cycle; reset is synchronous and leaves the element memory as is.
// After the request marked tlast the sequencer takes the bounds from each row's first and
// last element, then runs I <= DATA_WIDTH+1 search iterations, each counting the elements
// at most the midpoint with P <= clog2(cols+1) probes a row, each a memory read and compare.
// Input stalls while the sequencer is busy; a finished result waits in the output
// register, and the next search holds in its last step until that one is taken.
module sorted_rows_matrix_median_unit #(
  parameter int MAX_ROWS   = 16,
  parameter int MAX_COLS   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [srmm_pkg::IN_W-1:0]    in_tdata,   // [31:0] element_value
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [srmm_pkg::OUT_W-1:0]   out_tdata,  // [31:0] median_value
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [srmm_pkg::DIM_W-1:0]   cfg_wdata
);
  import srmm_pkg::*;

  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LI_W        = $clog2(STORE_DEPTH + 1);

  logic [DIM_W-1:0]      row_count_r;
  logic [DIM_W-1:0]      col_count_r;
  logic [LI_W-1:0]       load_idx_r;
  logic [LI_W-1:0]       load_idx_nxt;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r;

  ctrl_t                 ctrl;
  status_t               status;
  flags_t                flags;
  logic [STEP_W-1:0]     step;
  logic                  in_acc;
  logic                  store_we;
  logic                  mem_rd;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic [DATA_WIDTH-1:0] best;
  logic                  out_ld;

  assign in_tready  = step == STEP_IDLE;
  assign in_acc     = in_tvalid && in_tready;
  assign store_we   = in_acc && (load_idx_r < LI_W'(STORE_DEPTH));
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign status.start    = in_acc && in_tlast;
  assign status.out_free = !out_valid_r || out_tready;
  assign status.dp       = flags;
  assign out_ld          = ctrl.out_ld && status.out_free;

  srmm_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl),
    .step   (step)
  );

  srmm_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW),
    .DW    (DATA_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (AW'(load_idx_r)),
    .wdata (DATA_WIDTH'(in_tdata)),
    .rd    (mem_rd),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  srmm_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .AW       (AW),
    .DW       (DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .ctrl     (ctrl),
    .cfg_rows (row_count_r),
    .cfg_cols (col_count_r),
    .rdata    (mem_rdata),
    .mem_rd   (mem_rd),
    .mem_addr (mem_addr),
    .flags    (flags),
    .best     (best)
  );

  // saturate at the memory size, rewind after the last request
  always_comb begin
    load_idx_nxt = load_idx_r;
    if (in_acc) begin
      if (in_tlast) begin
        load_idx_nxt = '0;
      end else if (store_we) begin
        load_idx_nxt = load_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= DIM_W'(1);
      col_count_r <= DIM_W'(1);
      load_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      load_idx_r <= load_idx_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROW_COUNT: row_count_r <= cfg_wdata;
          CFG_COL_COUNT: col_count_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_data_r <= OUT_W'(best);
    end
  end

  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_idx_r <= LI_W'(STORE_DEPTH))
    else $error("load index ran past the element memory");

  a_start_init: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (step == STEP_INIT && load_idx_r == '0))
    else $error("last element did not start the search");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |=> (out_tvalid && $past(step) == STEP_DONE && step == STEP_IDLE))
    else $error("result not presented after the search finished");

  a_busy_no_input: assert property (@(posedge clk) disable iff (!rst_n)
    (step != STEP_IDLE) |-> !store_we)
    else $error("element written while the search runs");

endmodule

// File: sv/srmm_seq.sv
`timescale 1ns / 1ps
module srmm_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srmm_pkg::status_t             status,
  output srmm_pkg::ctrl_t               ctrl,
  output logic [srmm_pkg::STEP_W-1:0]   step
);
  import srmm_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              hit;

  assign ctrl = ucode(step_r);
  assign step = step_r;

  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS:    hit = 1'b1;
      COND_START:     hit = status.start;
      COND_MORE_ROWS: hit = status.dp.more_rows;
      COND_EMPTY:     hit = status.dp.empty;
      COND_N_ZERO:    hit = status.dp.n_zero;
      COND_OUT_FREE:  hit = status.out_free;
      default:        hit = 1'b0;
    endcase
    if (hit) begin
      step_nxt = ctrl.target;
    end else if (ctrl.hold) begin
      step_nxt = step_r;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: sv/srmm_store.sv
`timescale 1ns / 1ps
module srmm_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          rd,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// File: sv/srmm_dp.sv
`timescale 1ns / 1ps
module srmm_dp #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16,
  parameter int AW       = 8,
  parameter int DW       = 32
) (
  input  logic                        clk,
  input  srmm_pkg::ctrl_t             ctrl,
  input  logic [srmm_pkg::DIM_W-1:0]  cfg_rows,
  input  logic [srmm_pkg::DIM_W-1:0]  cfg_cols,
  input  logic [DW-1:0]               rdata,
  output logic                        mem_rd,
  output logic [AW-1:0]               mem_addr,
  output srmm_pkg::flags_t            flags,
  output logic [DW-1:0]               best
);
  import srmm_pkg::*;

  localparam int ADW = AW + DIM_W + 1;
  localparam int BW  = DW + 1;

  logic [DIM_W-1:0]     rows;
  logic [DIM_W-1:0]     cols;
  logic [CNT_W:0]       rank_calc;

  logic signed [BW-1:0] lo_r, lo_nxt;
  logic signed [BW-1:0] hi_r, hi_nxt;
  logic signed [DW-1:0] mid_r;
  logic [DW-1:0]        best_r, best_nxt;
  logic [CNT_W-1:0]     rank_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIM_W-1:0]     row_r, row_nxt;
  logic [AW-1:0]        base_r, base_nxt;
  logic [DIM_W-1:0]     first_r, first_nxt;
  logic [DIM_W-1:0]     n_r, n_nxt;

  logic [DIM_W-1:0]     half;
  logic signed [BW-1:0] elem;
  logic signed [BW:0]   mid_sum;
  logic signed [BW-1:0] mid_ext;
  logic                 below_rank;
  logic                 key_lt;

  // zero counts as one, anything above the maximum as the maximum
  always_comb begin
    if (cfg_rows == '0) begin
      rows = DIM_W'(1);
    end else if (32'(cfg_rows) > MAX_ROWS) begin
      rows = DIM_W'(MAX_ROWS);
    end else begin
      rows = cfg_rows;
    end
    if (cfg_cols == '0) begin
      cols = DIM_W'(1);
    end else if (32'(cfg_cols) > MAX_COLS) begin
      cols = DIM_W'(MAX_COLS);
    end else begin
      cols = cfg_cols;
    end
  end

  assign rank_calc  = ((CNT_W + 1)'(rows) * (CNT_W + 1)'(cols) + 1'b1) >> 1;
  assign half       = n_r >> 1;
  assign elem       = BW'($signed(rdata));
  assign mid_sum    = (BW + 1)'(lo_r) + (BW + 1)'(hi_r);
  assign mid_ext    = BW'(mid_r);
  assign below_rank = cnt_r < rank_r;
  assign key_lt     = mid_r < $signed(rdata);

  assign flags.more_rows = (row_r + 1'b1) < rows;
  assign flags.empty     = lo_r > hi_r;
  assign flags.n_zero    = n_r == '0;

  assign mem_rd = ctrl.mem_rd;
  assign best   = best_r;

  always_comb begin
    case (ctrl.addr_sel)
      ADDR_LAST:  mem_addr = AW'(ADW'(base_r) + ADW'(cols) - ADW'(1));
      ADDR_PROBE: mem_addr = AW'(ADW'(base_r) + ADW'(first_r) + ADW'(half));
      default:    mem_addr = base_r;
    endcase
  end

  always_comb begin
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    best_nxt  = best_r;
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    base_nxt  = base_r;
    first_nxt = first_r;
    n_nxt     = n_r;

    case (ctrl.lo_op)
      BND_LOAD: begin
        if (row_r == '0 || elem < lo_r) begin
          lo_nxt = elem;
        end
      end
      BND_DECIDE: begin
        if (below_rank) begin
          lo_nxt = mid_ext + BW'(1);
        end
      end
      default: ;
    endcase

    case (ctrl.hi_op)
      BND_LOAD: begin
        if (row_r == '0 || elem > hi_r) begin
          hi_nxt = elem;
        end
      end
      BND_DECIDE: begin
        if (!below_rank) begin
          hi_nxt = mid_ext - BW'(1);
        end
      end
      default: ;
    endcase

    case (ctrl.best_op)
      BEST_INIT:   best_nxt = '1;
      BEST_DECIDE: begin
        if (!below_rank) begin
          best_nxt = mid_r;
        end
      end
      default: ;
    endcase

    case (ctrl.cnt_op)
      CNT_CLEAR: cnt_nxt = '0;
      CNT_ADD:   cnt_nxt = cnt_r + CNT_W'(first_r);
      default: ;
    endcase

    case (ctrl.row_op)
      ROW_CLEAR: begin
        row_nxt  = '0;
        base_nxt = '0;
      end
      ROW_NEXT: begin
        row_nxt  = row_r + 1'b1;
        base_nxt = AW'(ADW'(base_r) + ADW'(cols));
      end
      default: ;
    endcase

    // upper-bound search within one row
    case (ctrl.prb_op)
      PRB_RESET: begin
        first_nxt = '0;
        n_nxt     = cols;
      end
      PRB_STEP: begin
        if (key_lt) begin
          n_nxt = half;
        end else begin
          first_nxt = first_r + half + 1'b1;
          n_nxt     = n_r - half - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    best_r  <= best_nxt;
    cnt_r   <= cnt_nxt;
    row_r   <= row_nxt;
    base_r  <= base_nxt;
    first_r <= first_nxt;
    n_r     <= n_nxt;
    if (ctrl.mid_ld) begin
      mid_r <= DW'(mid_sum >>> 1);
    end
    if (ctrl.rank_ld) begin
      rank_r <= CNT_W'(rank_calc);
    end
  end

endmodule
